>>> rtl/core/binary_projection_profile_defines.svh
// Assertion macros used by the checker of the projection profile block.
`ifndef BINARY_PROJECTION_PROFILE_DEFINES_SVH
`define BINARY_PROJECTION_PROFILE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bpp_pkg.sv
package bpp_pkg;

    localparam int PIXEL_W    = 8;
    localparam int THRESH_W   = 8;
    localparam int DIM_W      = 11;
    localparam int TOTAL_W    = 11;
    localparam int POS_W      = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - POS_W - TOTAL_W;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd50;
    localparam logic [DIM_W-1:0]    DIM_RESET    = 11'd1024;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_COLUMN = 1'b0,
        KIND_ROW    = 1'b1
    } kind_t;

    typedef struct packed {
        logic hit;
        logic first_row;
        logic last_col;
        logic last_row;
    } pix_flags_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] total;
        logic               frame_done;
    } result_t;

endpackage

>>> rtl/core/bpp_front.sv
module bpp_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bpp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpp_pkg::PIXEL_W-1:0]     pixel,
    input  logic                            s1_advance,
    output logic                            rd_en,
    output logic [CW-1:0]                   rd_addr,
    output logic                            s1_valid,
    output bpp_pkg::pix_flags_t             s1_flags,
    output logic [CW-1:0]                   s1_col,
    output logic [RW-1:0]                   s1_row,
    output logic [bpp_pkg::TOTAL_W-1:0]     s1_row_total
);
    import bpp_pkg::*;

    localparam int CMPW = ((CW + 1) > DIM_W) ? (CW + 1) : ((RW + 1) > DIM_W) ? (RW + 1) : DIM_W;
    localparam int CMPW2 = ((RW + 1) > CMPW) ? (RW + 1) : CMPW;

    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [CW-1:0]       col_pos_reg, col_pos_next;
    logic [RW-1:0]       row_pos_reg, row_pos_next;
    logic [TOTAL_W-1:0]  row_total_reg, row_total_next;
    logic                s1_valid_reg, s1_valid_next;
    pix_flags_t          s1_flags_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [RW-1:0]       s1_row_reg;
    logic [TOTAL_W-1:0]  s1_row_total_reg;

    logic                accept;
    logic                hit;
    logic                last_col;
    logic                last_row;
    logic [CMPW2-1:0]    col_inc;
    logic [CMPW2-1:0]    row_inc;
    logic [TOTAL_W-1:0]  row_sum;
    pix_flags_t          flags;

    assign s_tready = !s1_valid_reg || s1_advance;
    assign accept   = s_tvalid && s_tready;

    assign hit      = pixel > threshold_reg;
    assign col_inc  = CMPW2'(col_pos_reg) + CMPW2'(1);
    assign row_inc  = CMPW2'(row_pos_reg) + CMPW2'(1);
    assign last_col = (col_inc >= CMPW2'(frame_width_reg)) || (col_inc >= CMPW2'(MAX_WIDTH));
    assign last_row = (row_inc >= CMPW2'(frame_height_reg)) || (row_inc >= CMPW2'(MAX_HEIGHT));
    assign row_sum  = row_total_reg + TOTAL_W'(hit);

    always_comb begin
        flags.hit       = hit;
        flags.first_row = (row_pos_reg == '0);
        flags.last_col  = last_col;
        flags.last_row  = last_row;
    end

    always_comb begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        row_total_next = row_total_reg;
        if (accept) begin
            if (last_col) begin
                col_pos_next   = '0;
                row_pos_next   = last_row ? '0 : row_inc[RW-1:0];
                row_total_next = '0;
            end else begin
                col_pos_next   = col_inc[CW-1:0];
                row_total_next = row_sum;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESH_RESET;
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_THRESHOLD:    threshold_reg    <= cfg_wdata[THRESH_W-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_total_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            row_total_reg <= row_total_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_flags_reg     <= flags;
            s1_col_reg       <= col_pos_reg;
            s1_row_reg       <= row_pos_reg;
            s1_row_total_reg <= row_sum;
        end
    end

    assign rd_en        = accept;
    assign rd_addr      = col_pos_reg;
    assign s1_valid     = s1_valid_reg;
    assign s1_flags     = s1_flags_reg;
    assign s1_col       = s1_col_reg;
    assign s1_row       = s1_row_reg;
    assign s1_row_total = s1_row_total_reg;

endmodule

>>> rtl/core/bpp_colmem.sv
module bpp_colmem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [bpp_pkg::TOTAL_W-1:0]  wr_data,
    output logic [bpp_pkg::TOTAL_W-1:0]  rd_data
);
    import bpp_pkg::*;

    logic [TOTAL_W-1:0] mem [DEPTH];
    logic [TOTAL_W-1:0] rd_data_reg;
    logic [TOTAL_W-1:0] byp_data_reg;
    logic               byp_reg;

    // A read that meets a write to the same column in the same cycle takes the new value.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

>>> rtl/core/bpp_outq.sv
module bpp_outq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push_first,
    input  logic                            push_second,
    input  bpp_pkg::result_t                data_first,
    input  bpp_pkg::result_t                data_second,
    output logic                            room,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import bpp_pkg::*;

    localparam int PW   = $clog2(OUTQ_DEPTH);
    localparam int CNTW = $clog2(OUTQ_DEPTH + 1);

    result_t         q_reg [OUTQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            pop;
    result_t         head;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_first) + PW'(push_second);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CNTW'(push_first) + CNTW'(push_second) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_first) begin
            q_reg[wr_ptr_reg] <= data_first;
        end
        if (push_second) begin
            q_reg[wr_ptr_reg + PW'(1)] <= data_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign room     = count_reg <= CNTW'(OUTQ_DEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {M_PAD_W'(0), head.total, head.position};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.frame_done;

endmodule

>>> rtl/core/binary_projection_profile.sv
// Channel   Direction  tdata (low bit up)          tuser   tlast
// s_        in         pixel[7:0]                  -       -
// m_        out        position[9:0], total[20:10] kind    frame_done
// cfg_      in         write index cfg_addr, value cfg_wdata, no handshake
//
// One pixel is taken per cycle unless stalled; its results pass stage one and the queue.
// The column count memory is read as a pixel enters stage one and written as it leaves.
// Reset is synchronous: counters clear, registers take their defaults, the queue empties.
// The input stalls while stage one is full and the four-entry result queue holds more
// than two; the last pixel of the last row yields two results, all others at most one.
module binary_projection_profile #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bpp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpp_pkg::S_TDATA_W-1:0]   s_tdata,   // pixel[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpp_pkg::M_TDATA_W-1:0]   m_tdata,   // position[9:0], total[20:10]
    output logic                            m_tuser,   // kind
    output logic                            m_tlast
);
    import bpp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               s1_valid;
    pix_flags_t         s1_flags;
    logic [CW-1:0]      s1_col;
    logic [RW-1:0]      s1_row;
    logic [TOTAL_W-1:0] s1_row_total;
    logic               s1_advance;
    logic               room;
    logic [TOTAL_W-1:0] rd_data;
    logic [TOTAL_W-1:0] col_total;
    result_t            col_res;
    result_t            row_res;
    result_t            data_first;
    logic               push_first;
    logic               push_second;

    assign s1_advance = s1_valid && room;

    bpp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel        (s_tdata[PIXEL_W-1:0]),
        .s1_advance   (s1_advance),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1_valid     (s1_valid),
        .s1_flags     (s1_flags),
        .s1_col       (s1_col),
        .s1_row       (s1_row),
        .s1_row_total (s1_row_total)
    );

    bpp_colmem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_colmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (s1_advance),
        .wr_addr (s1_col),
        .wr_data (col_total),
        .rd_data (rd_data)
    );

    assign col_total = s1_flags.first_row ? TOTAL_W'(s1_flags.hit)
                                          : rd_data + TOTAL_W'(s1_flags.hit);

    always_comb begin
        col_res.kind        = KIND_COLUMN;
        col_res.position    = POS_W'(s1_col);
        col_res.total       = col_total;
        col_res.frame_done  = 1'b0;
        row_res.kind        = KIND_ROW;
        row_res.position    = POS_W'(s1_row);
        row_res.total       = s1_row_total;
        row_res.frame_done  = s1_flags.last_row;
    end

    // The column total goes ahead of the row total when a pixel makes both.
    assign data_first  = s1_flags.last_row ? col_res : row_res;
    assign push_first  = s1_advance && (s1_flags.last_row || s1_flags.last_col);
    assign push_second = s1_advance && s1_flags.last_row && s1_flags.last_col;

    bpp_outq u_outq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_first  (push_first),
        .push_second (push_second),
        .data_first  (data_first),
        .data_second (row_res),
        .room        (room),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> rtl/core/bpp_checker.sv
`include "binary_projection_profile_defines.svh"

module bpp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bpp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast
);
    import bpp_pkg::*;

    `BPP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "Stalled result transfer changed.")

    `BPP_ASSERT_SAME(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready,
        "Input stalled with no result pending.")

    `BPP_ASSERT_SAME(a_last_is_row, aclk, aresetn, m_tvalid && m_tlast, m_tuser == KIND_ROW,
        "Frame end flagged on a column total.")

    `BPP_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid,
        m_tdata[M_TDATA_W-1:POS_W+TOTAL_W] == '0, "Result padding bits not zero.")

endmodule

bind binary_projection_profile bpp_checker u_bpp_checker (.*);

>>> verif/bpp_profile_checker.sv
module bpp_profile_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bpp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bpp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [bpp_pkg::S_TDATA_W-1:0]    s_tdata,   // pixel[7:0]
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bpp_pkg::M_TDATA_W-1:0]    m_tdata,   // position[9:0], total[20:10]
    input  logic                             m_tuser,   // kind
    input  logic                             m_tlast,
    output int                               failures,
    output int                               pending
);
    import bpp_pkg::*;

    logic [THRESH_W-1:0] thr;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [TOTAL_W-1:0]  column_hits [MAX_WIDTH];
    logic [TOTAL_W-1:0]  row_hits;
    int unsigned         col_at;
    int unsigned         row_at;
    result_t             profile_q[$];
    int                  mismatches = 0;
    int                  outstanding = 0;

    assign failures = mismatches;
    assign pending  = outstanding;

    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        int unsigned        idx;
        logic               hit;
        logic               last_row;
        logic [TOTAL_W-1:0] col_sum;
        result_t            r;
        w        = effective_dim(width_reg, MAX_WIDTH);
        h        = effective_dim(height_reg, MAX_HEIGHT);
        hit      = px > thr;
        idx      = col_at % MAX_WIDTH;
        last_row = row_at >= h - 1;
        if (row_at == 0) begin
            col_sum = TOTAL_W'(hit);
        end else begin
            col_sum = column_hits[idx] + TOTAL_W'(hit);
        end
        column_hits[idx] = col_sum;
        row_hits = row_hits + TOTAL_W'(hit);
        if (last_row) begin
            r.kind       = KIND_COLUMN;
            r.position   = col_at[POS_W-1:0];
            r.total      = col_sum;
            r.frame_done = 1'b0;
            profile_q.push_back(r);
        end
        if (col_at >= w - 1) begin
            r.kind       = KIND_ROW;
            r.position   = row_at[POS_W-1:0];
            r.total      = row_hits;
            r.frame_done = last_row;
            profile_q.push_back(r);
            row_hits = '0;
            col_at   = 0;
            row_at   = last_row ? 0 : row_at + 1;
        end else begin
            col_at = col_at + 1;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            thr        = THRESH_RESET;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            row_hits   = '0;
            col_at     = 0;
            row_at     = 0;
            foreach (column_hits[i]) column_hits[i] = '0;
            profile_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_THRESHOLD:    thr        = cfg_wdata[THRESH_W-1:0];
                    CFG_FRAME_WIDTH:  width_reg  = cfg_wdata[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_pixel(s_tdata[PIXEL_W-1:0]);
            if (m_tvalid && m_tready) begin
                got.kind       = kind_t'(m_tuser);
                got.position   = m_tdata[POS_W-1:0];
                got.total      = m_tdata[POS_W +: TOTAL_W];
                got.frame_done = m_tlast;
                if (profile_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %s",
                             $time, $sformatf("kind=%0d pos=%0d total=%0d done=%0d",
                             got.kind, got.position, got.total, got.frame_done));
                end else begin
                    want = profile_q.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.total !== want.total || got.frame_done !== want.frame_done) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected kind=%0d pos=%0d total=%0d done=%0d",
                                 $time, want.kind, want.position, want.total,
                                 want.frame_done);
                        $display("%0t:                  actual kind=%0d pos=%0d total=%0d done=%0d",
                                 $time, got.kind, got.position, got.total, got.frame_done);
                    end
                end
            end
        end
        outstanding = profile_q.size();
    end

endmodule

>>> verif/tb.sv
module tb;
    import bpp_pkg::*;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int TOTAL_ITEMS = 1150;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    failures;
    int                    pending;

    int                    tx_idle;
    int                    rx_idle;
    int                    items_sent;
    int                    cur_w;
    int                    cur_h;
    int                    col_at;
    int                    row_at;
    logic [THRESH_W-1:0]   thr_now;
    bit                    hold_req;
    bit                    hold_done;

    binary_projection_profile #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bpp_profile_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) profile_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4800000;
        $display("FAILURE");
        $finish;
    end

    // The receiver stalls once for a long stretch so that the result queue fills
    // and the block has to hold off its input.
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && hold_req) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic int dim_of(input int v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return thr_now;
            3:       return thr_now + 8'd1;
            default: return PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    task automatic set_reg(input cfg_index_t idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_THRESHOLD:    thr_now = value[THRESH_W-1:0];
            CFG_FRAME_WIDTH:  cur_w   = dim_of(value, MAX_WIDTH);
            CFG_FRAME_HEIGHT: cur_h   = dim_of(value, MAX_HEIGHT);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        if (items_sent < TOTAL_ITEMS / 3) begin
            tx_idle = 8;
            rx_idle = 53;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            tx_idle = 53;
            rx_idle = 8;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        if (col_at >= cur_w - 1) begin
            col_at = 0;
            row_at = (row_at >= cur_h - 1) ? 0 : row_at + 1;
        end else begin
            col_at++;
        end
        items_sent++;
    endtask

    // Drops valid, waits for every predicted result, then lets the pipeline settle.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin : stimulus
        int nw;
        int nh;
        int n;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        thr_now    = THRESH_RESET;
        cur_w      = DIM_RESET;
        cur_h      = DIM_RESET;
        col_at     = 0;
        row_at     = 0;
        tx_idle    = 8;
        rx_idle    = 53;
        items_sent = 0;
        hold_req   = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, then the geometry shrinks in the middle of the first row.
        send_pixel(8'd50);
        send_pixel(8'd51);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_quiet();
        set_reg(CFG_FRAME_WIDTH, 4);
        set_reg(CFG_FRAME_HEIGHT, 2);
        send_pixel(8'd100);
        send_pixel(8'd50);
        send_pixel(8'd51);
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_quiet();

        // Zero dimensions act as one pixel per frame; the top threshold gives no hits.
        set_reg(CFG_THRESHOLD, 255);
        set_reg(CFG_FRAME_WIDTH, 0);
        set_reg(CFG_FRAME_HEIGHT, 0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_quiet();

        // Oversized height clamps, then shrinks so that the current row ends the frame.
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_FRAME_WIDTH, 3);
        set_reg(CFG_FRAME_HEIGHT, 2047);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd128);
        wait_quiet();
        set_reg(CFG_FRAME_HEIGHT, 1);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd7);
        wait_quiet();

        set_reg(CFG_THRESHOLD, 254);
        set_reg(CFG_FRAME_WIDTH, 2);
        set_reg(CFG_FRAME_HEIGHT, 3);
        send_pixel(8'd254);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd254);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_quiet();

        // One full frame at the widest row, every pixel closing a column.
        set_reg(CFG_THRESHOLD, $urandom_range(255));
        set_reg(CFG_FRAME_WIDTH, 2047);
        set_reg(CFG_FRAME_HEIGHT, 1);
        hold_req = 1'b1;
        repeat (MAX_WIDTH) send_pixel(pick_pixel());
        wait_quiet();

        // A tall single-column frame, cut short by shrinking the height.
        set_reg(CFG_FRAME_WIDTH, 1);
        set_reg(CFG_FRAME_HEIGHT, MAX_HEIGHT);
        repeat (40) send_pixel(pick_pixel());
        wait_quiet();
        set_reg(CFG_FRAME_HEIGHT, 1);
        send_pixel(pick_pixel());

        while (items_sent < TOTAL_ITEMS) begin
            wait_quiet();
            case ($urandom_range(3))
                0: set_reg(CFG_THRESHOLD, 0);
                1: set_reg(CFG_THRESHOLD, 255);
                2: set_reg(CFG_THRESHOLD, $urandom_range(255));
                default: ;
            endcase
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(11))
                    0:       nw = 0;
                    1:       nw = 2047;
                    2:       nw = MAX_WIDTH;
                    default: nw = $urandom_range(1, 24);
                endcase
                // Past the first row a wider row would read columns never counted.
                if (row_at != 0 && dim_of(nw, MAX_WIDTH) > cur_w) nw = cur_w;
                set_reg(CFG_FRAME_WIDTH, nw);
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(11))
                    0:       nh = 0;
                    1:       nh = 2047;
                    default: nh = $urandom_range(1, 12);
                endcase
                set_reg(CFG_FRAME_HEIGHT, nh);
            end
            n = $urandom_range(10, 90);
            repeat (n) begin
                send_pixel(pick_pixel());
            end
        end

        wait_quiet();
        repeat (20) @(negedge aclk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bpp_pkg.sv
rtl/core/bpp_front.sv
rtl/core/bpp_colmem.sv
rtl/core/bpp_outq.sv
rtl/core/binary_projection_profile.sv
rtl/core/bpp_checker.sv
verif/bpp_profile_checker.sv
verif/tb.sv
